>>> rtl/ssrc_pkg.sv
// shared types, constants and helpers for the slot status ring channel
// no dependencies; ssrc_core and slot_status_ring_channel import this package
`default_nettype none

package ssrc_pkg;

  localparam int INDEX_BITS = 6;
  localparam int ID_BITS    = 10;
  localparam int TYPE_BITS  = 2;
  localparam int TAG_BITS   = TYPE_BITS + ID_BITS;
  localparam int SLOT_BITS  = 1 + TAG_BITS;
  localparam int DEPTH      = 1 << INDEX_BITS;
  localparam int KIND_BITS  = 3;
  localparam int STAT_BITS  = 2;
  localparam int LOG2_BITS  = 3;

  localparam logic [LOG2_BITS-1:0] RING_SIZE_RESET = LOG2_BITS'(INDEX_BITS);
  localparam logic [TYPE_BITS-1:0] TYPE_REQUEST    = TYPE_BITS'(1);

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [TAG_BITS-1:0]   tag_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_CLAIM   = 3'd0,
    KIND_MARK    = 3'd1,
    KIND_TAKE    = 3'd2,
    KIND_POLL    = 3'd3,
    KIND_RELEASE = 3'd4
  } kind_t;

  typedef enum logic [STAT_BITS-1:0] {
    STATUS_DONE        = 2'd0,
    STATUS_BLOCK       = 2'd1,
    STATUS_NOT_REQUEST = 2'd2
  } status_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    index_t               entry_index;
    tag_t                 message_tag;
  } cmd_t;

  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    index_t               granted_entry;
    logic [TYPE_BITS-1:0] message_kind;
    logic [ID_BITS-1:0]   reply_cookie;
  } rsp_t;

  // one ring entry as stored: full mark and tag
  typedef struct packed {
    logic full;
    tag_t tag;
  } slot_t;

  typedef struct packed {
    logic   en;
    index_t addr;
    slot_t  data;
  } ram_wr_t;

  // index mask for a ring of 2**lg entries, clamped to the full index width
  function automatic index_t ring_mask(logic [LOG2_BITS-1:0] lg);
    index_t m;
    for (int i = 0; i < INDEX_BITS; i++) begin
      m[i] = (int'(lg) > i);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/slot_status_ring_channel.sv
// slot status ring channel: the command register and then the result register lie
// between start and result_strobe; throughput one command per cycle once the entries are cleared
// the receiver cannot stall; each result shows for exactly one cycle
// synchronous active-high rst: both counters zero, ring size 64; busy then
// stays high while every entry is marked free, one per cycle
// depends on ssrc_pkg, ssrc_core and ssrc_ram
`default_nettype none

module slot_status_ring_channel
  import ssrc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // command side
  input  wire logic                 start,
  output logic                      busy,
  input  wire cmd_t                 cmd,
  // result side
  output logic                      result_strobe,
  output rsp_t                      result,
  // ring size register write
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [LOG2_BITS-1:0] cfg_data
);

  logic [LOG2_BITS-1:0] ring_size_log2, ring_size_log2_next;
  index_t               mask, mask_next;
  ram_wr_t              ram_wr;
  index_t               head_rd_addr;
  slot_t                head_rd_data;
  index_t               prod_rd_addr;
  logic                 prod_rd_data;

  // the ring size register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // ring size register
  assign ring_size_log2_next = (cfg_valid && cfg_ready) ? cfg_data : ring_size_log2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size_log2 <= RING_SIZE_RESET;
    end else begin
      ring_size_log2 <= ring_size_log2_next;
    end
  end

  // current mask for the executing command, next mask for the prefetch
  assign mask      = ring_mask(ring_size_log2);
  assign mask_next = ring_mask(ring_size_log2_next);

  // execution: counters, entry clearing, command and result registers
  ssrc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .mask         (mask),
    .mask_next    (mask_next),
    .ram_wr       (ram_wr),
    .head_rd_addr (head_rd_addr),
    .head_rd_data (head_rd_data),
    .prod_rd_addr (prod_rd_addr),
    .prod_rd_data (prod_rd_data),
    .rsp_strobe   (result_strobe),
    .rsp          (result)
  );

  // full mark and tag per entry, read at the head
  ssrc_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (DEPTH)
  ) u_head_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_addr (head_rd_addr),
    .rd_data (head_rd_data)
  );

  // copy of the full marks, read at the produce entry
  ssrc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_mark_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data.full),
    .rd_addr (prod_rd_addr),
    .rd_data (prod_rd_data)
  );

endmodule

`default_nettype wire

>>> rtl/ssrc_ram.sv
// generic single write port, single read port ram with registered read
// no package dependency
`default_nettype none

module ssrc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/ssrc_core.sv
// ring control: command register, counters, mark clearing, execution and result register
// depends on ssrc_pkg; marks and tags live in external ssrc_ram instances
`default_nettype none

module ssrc_core
  import ssrc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire cmd_t    cmd,
  input  wire index_t  mask,
  input  wire index_t  mask_next,
  output ram_wr_t      ram_wr,
  output index_t       head_rd_addr,
  input  wire slot_t   head_rd_data,
  output index_t       prod_rd_addr,
  input  wire logic    prod_rd_data,
  output logic         rsp_strobe,
  output rsp_t         rsp
);

  logic   clearing;
  index_t clear_idx;
  logic   item_valid;
  cmd_t   item;
  index_t produce_count, produce_count_next;
  index_t consume_count, consume_count_next;
  logic   head_fwd_hit;
  logic   prod_fwd_hit;
  slot_t  fwd_slot;
  rsp_t   rsp_next;

  index_t addr, prod_idx, head_idx;
  slot_t  head_slot;
  logic   prod_full;

  assign busy      = clearing;
  assign addr      = item.entry_index & mask;
  assign prod_idx  = produce_count & mask;
  assign head_idx  = consume_count & mask;
  assign head_slot = head_fwd_hit ? fwd_slot : head_rd_data;
  assign prod_full = prod_fwd_hit ? fwd_slot.full : prod_rd_data;

  always_comb begin
    rsp_next           = '0;
    produce_count_next = produce_count;
    consume_count_next = consume_count;
    ram_wr             = '0;
    if (clearing) begin
      // mark one entry free per cycle after reset
      ram_wr.en   = 1'b1;
      ram_wr.addr = clear_idx;
    end else if (item_valid) begin
      case (item.kind)
        KIND_CLAIM: begin
          if (!prod_full) begin
            rsp_next.granted_entry = prod_idx;
            produce_count_next     = produce_count + 1'b1;
          end else begin
            rsp_next.status = STATUS_BLOCK;
          end
        end
        KIND_MARK: begin
          ram_wr.en              = 1'b1;
          ram_wr.addr            = addr;
          ram_wr.data.full       = 1'b1;
          ram_wr.data.tag        = item.message_tag;
          rsp_next.granted_entry = addr;
        end
        KIND_TAKE: begin
          if (head_slot.full) begin
            rsp_next.granted_entry = head_idx;
            rsp_next.message_kind  = head_slot.tag[TYPE_BITS-1:0];
            consume_count_next     = consume_count + 1'b1;
          end else begin
            rsp_next.status = STATUS_BLOCK;
          end
        end
        KIND_POLL: begin
          if (!head_slot.full) begin
            rsp_next.status = STATUS_BLOCK;
          end else begin
            rsp_next.message_kind = head_slot.tag[TYPE_BITS-1:0];
            if (head_slot.tag[TYPE_BITS-1:0] == TYPE_REQUEST) begin
              rsp_next.granted_entry = head_idx;
              consume_count_next     = consume_count + 1'b1;
            end else begin
              rsp_next.status       = STATUS_NOT_REQUEST;
              rsp_next.reply_cookie = head_slot.tag[TAG_BITS-1:TYPE_BITS];
            end
          end
        end
        KIND_RELEASE: begin
          ram_wr.en              = 1'b1;
          ram_wr.addr            = addr;
          ram_wr.data.full       = 1'b0;
          rsp_next.granted_entry = addr;
        end
        default: begin
          rsp_next = '0;
        end
      endcase
    end
  end

  // prefetch the head entry and the produce entry for whatever item runs next
  assign head_rd_addr = consume_count_next & mask_next;
  assign prod_rd_addr = produce_count_next & mask_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clear_idx     <= '0;
      item_valid    <= 1'b0;
      rsp_strobe    <= 1'b0;
      produce_count <= '0;
      consume_count <= '0;
      head_fwd_hit  <= 1'b0;
      prod_fwd_hit  <= 1'b0;
    end else begin
      if (clearing) begin
        clear_idx <= clear_idx + 1'b1;
        if (&clear_idx) begin
          clearing <= 1'b0;
        end
      end
      item_valid    <= start && !clearing;
      rsp_strobe    <= item_valid;
      produce_count <= produce_count_next;
      consume_count <= consume_count_next;
      head_fwd_hit  <= ram_wr.en && (ram_wr.addr == head_rd_addr);
      prod_fwd_hit  <= ram_wr.en && (ram_wr.addr == prod_rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_slot <= ram_wr.data;
    if (start) begin
      item <= cmd;
    end
    if (item_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/ssrc_ring_checker.sv
// request and reply checker for the slot status ring channel
// keeps its own copy of the ring marks, tags, counters and ring size and
// compares every reply strobe with the oldest prediction; needs ssrc_pkg
module ssrc_ring_checker
  import ssrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  cmd_t                 cmd,
  input  logic                 result_strobe,
  input  rsp_t                 result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [LOG2_BITS-1:0] cfg_data,
  output int                   mismatch_count,
  output int                   pending
);

  logic                 slot_full [DEPTH];
  tag_t                 slot_tag  [DEPTH];
  index_t               produce_ptr;
  index_t               consume_ptr;
  logic [LOG2_BITS-1:0] ring_lg;
  rsp_t                 expected_replies [$];
  rsp_t                 oldest;

  // entries in use are the low ring_lg index bits, never more than the index
  function automatic index_t span_mask();
    int lg;
    lg = (int'(ring_lg) > INDEX_BITS) ? INDEX_BITS : int'(ring_lg);
    return index_t'((1 << lg) - 1);
  endfunction

  // one ring access: updates the shadow state and returns the reply
  function automatic rsp_t ring_access(cmd_t c);
    rsp_t   r;
    index_t m;
    index_t slot;
    index_t tail;
    index_t head;
    r    = '0;
    m    = span_mask();
    slot = c.entry_index & m;
    tail = produce_ptr & m;
    head = consume_ptr & m;
    case (c.kind)
      KIND_CLAIM: begin
        if (!slot_full[tail]) begin
          r.granted_entry = tail;
          produce_ptr++;
        end else begin
          r.status = STATUS_BLOCK;
        end
      end
      KIND_MARK: begin
        slot_full[slot] = 1'b1;
        slot_tag[slot]  = c.message_tag;
        r.granted_entry = slot;
      end
      KIND_TAKE: begin
        if (slot_full[head]) begin
          r.granted_entry = head;
          r.message_kind  = slot_tag[head][TYPE_BITS-1:0];
          consume_ptr++;
        end else begin
          r.status = STATUS_BLOCK;
        end
      end
      KIND_POLL: begin
        if (!slot_full[head]) begin
          r.status = STATUS_BLOCK;
        end else begin
          r.message_kind = slot_tag[head][TYPE_BITS-1:0];
          if (r.message_kind == TYPE_REQUEST) begin
            r.granted_entry = head;
            consume_ptr++;
          end else begin
            r.status       = STATUS_NOT_REQUEST;
            r.reply_cookie = slot_tag[head][TAG_BITS-1:TYPE_BITS];
          end
        end
      end
      KIND_RELEASE: begin
        slot_full[slot] = 1'b0;
        r.granted_entry = slot;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_full[i] = 1'b0;
        slot_tag[i]  = '0;
      end
      produce_ptr    = '0;
      consume_ptr    = '0;
      ring_lg        = RING_SIZE_RESET;
      mismatch_count = 0;
      expected_replies.delete();
    end else begin
      if (result_strobe === 1'b1) begin
        if (expected_replies.size() == 0) begin
          $error("reply with no request outstanding");
          mismatch_count++;
        end else begin
          oldest = expected_replies.pop_front();
          if (result.status !== oldest.status) begin
            $error("status expected %0d actual %0d", oldest.status, result.status);
            mismatch_count++;
          end
          if (result.granted_entry !== oldest.granted_entry) begin
            $error("granted_entry expected %0d actual %0d",
                   oldest.granted_entry, result.granted_entry);
            mismatch_count++;
          end
          if (result.message_kind !== oldest.message_kind) begin
            $error("message_kind expected %0d actual %0d",
                   oldest.message_kind, result.message_kind);
            mismatch_count++;
          end
          if (result.reply_cookie !== oldest.reply_cookie) begin
            $error("reply_cookie expected %0d actual %0d",
                   oldest.reply_cookie, result.reply_cookie);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        ring_lg = cfg_data;
      end
      if (start && !busy) begin
        expected_replies.push_back(ring_access(cmd));
      end
    end
    pending = expected_replies.size();
  end

endmodule

>>> tb/sv/testbench.sv
// top of the slot status ring channel testbench: clock, reset, requests,
// ring size writes and the verdict; checking lives in ssrc_ring_checker
// needs ssrc_pkg, slot_status_ring_channel and ssrc_ring_checker
module testbench;
  import ssrc_pkg::*;

  // generous watchdog bound, even at the heaviest idling
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  cmd_t                 cmd;
  logic                 result_strobe;
  rsp_t                 result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LOG2_BITS-1:0] cfg_data;
  int                   mismatch_count;
  int                   pending;
  int                   cycle_count;

  // stimulus bookkeeping: a well-behaved producer and consumer keep their
  // own copy of the two ring counters, the fill level and the types sent
  int                   idle_pct;
  int                   items_sent;
  index_t               prod_ptr;
  index_t               cons_ptr;
  index_t               cur_mask;
  int                   cur_slots;
  int                   fill;
  logic [TYPE_BITS-1:0] sent_type [DEPTH];

  slot_status_ring_channel i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  ssrc_ring_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .result_strobe  (result_strobe),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost reply ends here
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one request; random idle cycles go in front of it at the current rate,
  // so gaps land before any kind of request and after any other
  task automatic issue(logic [KIND_BITS-1:0] k, index_t e, tag_t t);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start           = 1'b1;
    cmd.kind        = k;
    cmd.entry_index = e;
    cmd.message_tag = t;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // entry index aimed at the masked slot, with random bits above the mask
  // so the out-of-ring masking is exercised
  function automatic index_t aim(index_t slot);
    return (slot & cur_mask) | (index_t'($urandom) & ~cur_mask);
  endfunction

  function automatic tag_t random_tag();
    tag_t t;
    t = tag_t'($urandom);
    // about half requests so polls both grant and refuse
    if ($urandom_range(0, 1) == 1) t[TYPE_BITS-1:0] = TYPE_REQUEST;
    return t;
  endfunction

  // producer: claim the next entry, then mark it sent with a tag
  task automatic produce(tag_t t);
    index_t slot;
    slot = prod_ptr & cur_mask;
    issue(KIND_CLAIM, index_t'($urandom), tag_t'($urandom));
    issue(KIND_MARK, aim(slot), t);
    sent_type[slot] = t[TYPE_BITS-1:0];
    prod_ptr++;
    fill++;
  endtask

  // consumer: take the head (or poll it, falling back to a take when the
  // head is not a request), then release the entry
  task automatic consume(bit by_poll);
    index_t slot;
    slot = cons_ptr & cur_mask;
    if (by_poll) begin
      issue(KIND_POLL, index_t'($urandom), tag_t'($urandom));
      if (sent_type[slot] != TYPE_REQUEST) begin
        issue(KIND_TAKE, index_t'($urandom), tag_t'($urandom));
      end
    end else begin
      issue(KIND_TAKE, index_t'($urandom), tag_t'($urandom));
    end
    issue(KIND_RELEASE, aim(slot), tag_t'($urandom));
    cons_ptr++;
    fill--;
  endtask

  // let every reply come back, plus a margin for the two-stage pipe
  task automatic wait_quiet();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ring size write, only from an idle block
  task automatic set_ring_size(logic [LOG2_BITS-1:0] lg);
    wait_quiet();
    cfg_valid = 1'b1;
    cfg_data  = lg;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_mask  = (int'(lg) >= INDEX_BITS) ? '1 : index_t'((1 << lg) - 1);
    cur_slots = int'(cur_mask) + 1;
  endtask

  initial begin
    int unsigned phase_lg   [PHASES];
    int          phase_idle [PHASES];
    int          goal;
    int          pick;
    int          run;
    phase_lg   = '{7, 1, 2, 4, 5, 6};
    phase_idle = '{0, 70, 14, 0, 70, 14};

    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    idle_pct   = 0;
    items_sent = 0;
    prod_ptr   = '0;
    cons_ptr   = '0;
    cur_mask   = '1;
    cur_slots  = DEPTH;
    fill       = 0;
    for (int i = 0; i < DEPTH; i++) sent_type[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at the reset ring size of 64 entries
    // take and poll on an empty ring both block
    issue(KIND_TAKE, '1, '1);
    issue(KIND_POLL, '0, '0);
    // all-ones tag: type 3, id all ones; poll refuses with the id as cookie
    produce('1);
    issue(KIND_POLL, '1, '0);
    consume(1'b0);
    // request with id zero is granted by poll
    produce({{ID_BITS{1'b0}}, TYPE_REQUEST});
    consume(1'b1);
    // response type: poll refuses, take gets it
    produce({ID_BITS'(10'h155), TYPE_BITS'(2)});
    consume(1'b1);
    // mark and release work on any entry whatever its mark
    issue(KIND_MARK, '1, '0);
    issue(KIND_RELEASE, '1, '1);
    issue(KIND_RELEASE, '0, '0);
    // unused kinds change nothing and reply all zero
    for (int k = 1; k <= 3; k++) begin
      issue(KIND_BITS'(KIND_RELEASE + k), '1, '1);
    end
    issue(KIND_BITS'(KIND_RELEASE + 3), '0, '0);

    // single-entry ring: every index folds onto entry 0
    set_ring_size('0);
    produce(random_tag());
    issue(KIND_CLAIM, '1, '1);       // the only entry is full
    consume(1'b1);
    issue(KIND_TAKE, '0, '0);        // empty again
    // a claimed entry stays free until marked, so claiming twice works
    issue(KIND_CLAIM, '0, '0);
    issue(KIND_CLAIM, '1, '1);
    prod_ptr += 2;
    // mark and drain both claimed entries so the counters line up again
    repeat (2) begin
      issue(KIND_MARK, aim('0), random_tag());
      fill++;
      consume(1'b0);
    end

    // random phases, each at its own ring size and idle rate; most traffic
    // is producer and consumer bursts that fill and drain the ring, with
    // blocked probes at full and empty and some noise mixed in
    for (int p = 0; p < PHASES; p++) begin
      set_ring_size(LOG2_BITS'(phase_lg[p]));
      idle_pct = phase_idle[p];
      goal     = items_sent + 70;
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          issue(KIND_BITS'($urandom_range(KIND_RELEASE + 1, 7)),
                index_t'($urandom), tag_t'($urandom));
        end else if (pick < 9) begin
          // fully random request; may knock the bookkeeping off, harmless
          issue(KIND_BITS'($urandom_range(0, 7)), index_t'($urandom), random_tag());
        end else if (pick < 16 && fill == cur_slots) begin
          issue(KIND_CLAIM, index_t'($urandom), tag_t'($urandom));
        end else if (pick < 16 && fill == 0) begin
          issue($urandom_range(0, 1) ? KIND_POLL : KIND_TAKE,
                index_t'($urandom), tag_t'($urandom));
        end else if (fill == 0 || (fill < cur_slots && $urandom_range(0, 1) == 1)) begin
          run = $urandom_range(1, cur_slots);
          while (run > 0 && fill < cur_slots) begin
            produce(random_tag());
            run--;
          end
        end else begin
          run = $urandom_range(1, cur_slots);
          while (run > 0 && fill > 0) begin
            consume(1'($urandom_range(0, 1)));
            run--;
          end
        end
      end
      // empty the ring before the next size change
      while (fill > 0) consume(1'($urandom_range(0, 1)));
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
